### rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on clk, quiet during reset
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication or plain property that must hold at every edge out of reset
`define ASSERT_PROP(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition that must never be seen at any edge out of reset
`define ASSERT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

### rtl/core/ott_pkg.sv
// ---------------------------------------------------------------------------
// ott_pkg
// token codes, character constants, byte classes and shared token types
// ---------------------------------------------------------------------------
package ott_pkg;

	// token kind codes
	localparam logic [2:0] KIND_SLASH   = 3'd0;
	localparam logic [2:0] KIND_NEWLINE = 3'd1;
	localparam logic [2:0] KIND_NUMBER  = 3'd2;
	localparam logic [2:0] KIND_IDENT   = 3'd3;
	localparam logic [2:0] KIND_VERTEX  = 3'd4;
	localparam logic [2:0] KIND_ERROR   = 3'd5;

	// character constants
	localparam logic [7:0] CH_SLASH   = 8'h2F;
	localparam logic [7:0] CH_HASH    = 8'h23;
	localparam logic [7:0] CH_DOT     = 8'h2E;
	localparam logic [7:0] CH_VERTEX  = 8'h76;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_MINUS   = 8'h2D;

	// one result token as it leaves the block
	typedef struct packed {
		logic [2:0]  kind;
		logic [15:0] offset;
		logic [15:0] length;
		logic [15:0] line;
		logic        last;
	} token_t;

	// tokens produced by one byte, at most two
	typedef struct packed {
		logic [1:0] count;
		token_t     tok0;
		token_t     tok1;
	} lex_out_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
	endfunction

	// space, tab, vertical tab, form feed, carriage return
	function automatic logic is_blank(input logic [7:0] c);
		return (c == 8'h20) || (c == 8'h09) || (c == 8'h0B) || (c == 8'h0C) ||
			(c == 8'h0D);
	endfunction

endpackage

### rtl/core/ott_byte_if.sv
// ---------------------------------------------------------------------------
// ott_byte_if
// text byte channel: one byte or an end marker per transfer
// ---------------------------------------------------------------------------
interface ott_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_in;
	logic       at_end;

	modport source(output valid, char_in, at_end, input ready);
	modport sink(input valid, char_in, at_end, output ready);
endinterface

### rtl/core/ott_token_if.sv
// ---------------------------------------------------------------------------
// ott_token_if
// token channel: one token per transfer
// ---------------------------------------------------------------------------
interface ott_token_if;
	logic        valid;
	logic        ready;
	logic [2:0]  token_kind;
	logic [15:0] token_offset;
	logic [15:0] token_length;
	logic [15:0] line_number;
	logic        last_of_run;

	modport source(output valid, token_kind, token_offset, token_length, line_number,
		last_of_run, input ready);
	modport sink(input valid, token_kind, token_offset, token_length, line_number,
		last_of_run, output ready);
endinterface

### rtl/core/ott_lexer.sv
// ---------------------------------------------------------------------------
// ott_lexer
// scan state and per-byte token decision, up to two tokens per byte
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ott_lexer #(
	parameter int POS_BITS  = 16,
	parameter int LINE_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  logic [7:0]       char_in,
	input  logic             at_end,
	output ott_pkg::lex_out_t lex
);

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_INT,
		MODE_FRAC,
		MODE_IDENT,
		MODE_COMMENT,
		MODE_HALT
	} mode_t;

	mode_t                mode_q, mode_d;
	logic [POS_BITS-1:0]  off_q, off_d, start_q, start_d;
	logic [LINE_BITS-1:0] line_q, line_d;
	logic                 vtx_q, vtx_d;

	logic [POS_BITS-1:0]  q, diff;
	logic [LINE_BITS-1:0] line_inc;
	logic [31:0]          p_w, q_w, start_w, diff_w, line_w, inc_w;
	logic [15:0]          len_sat;
	logic                 pending, cont, flush, own_v;
	ott_pkg::token_t      pend_tok, own_tok;

	// positions and lengths trimmed to the 16-bit token fields
	assign q        = off_q + POS_BITS'(1);
	assign diff     = off_q - start_q;
	assign line_inc = line_q + LINE_BITS'(1);
	assign p_w      = 32'(off_q);
	assign q_w      = 32'(q);
	assign start_w  = 32'(start_q);
	assign diff_w   = 32'(diff);
	assign line_w   = 32'(line_q);
	assign inc_w    = 32'(line_inc);
	assign len_sat  = (diff_w > 32'h0000_FFFF) ? 16'hFFFF : diff_w[15:0];

	// token held open by the scan mode
	assign pending = (mode_q == MODE_INT) || (mode_q == MODE_FRAC) || (mode_q == MODE_IDENT);

	always_comb begin
		pend_tok.kind   = (mode_q == MODE_IDENT) ?
			(vtx_q ? ott_pkg::KIND_VERTEX : ott_pkg::KIND_IDENT) : ott_pkg::KIND_NUMBER;
		pend_tok.offset = start_w[15:0];
		pend_tok.length = len_sat;
		pend_tok.line   = line_w[15:0];
		pend_tok.last   = 1'b0;
	end

	// byte continues the open token
	always_comb begin
		case (mode_q)
			MODE_INT:   cont = ott_pkg::is_digit(char_in) || (char_in == ott_pkg::CH_DOT);
			MODE_FRAC:  cont = ott_pkg::is_digit(char_in);
			MODE_IDENT: cont = ott_pkg::is_digit(char_in) || ott_pkg::is_alpha(char_in);
			default:    cont = 1'b0;
		endcase
	end

	// next state and the tokens of this byte
	always_comb begin
		mode_d  = mode_q;
		off_d   = off_q;
		start_d = start_q;
		line_d  = line_q;
		vtx_d   = vtx_q;
		flush   = 1'b0;
		own_v   = 1'b0;
		own_tok = '0;
		if (fire && (mode_q != MODE_HALT)) begin
			if (at_end) begin
				// flush, then a zero-length newline at the current offset
				flush          = pending;
				own_v          = 1'b1;
				own_tok.kind   = ott_pkg::KIND_NEWLINE;
				own_tok.offset = p_w[15:0];
				own_tok.line   = line_w[15:0];
				mode_d         = MODE_IDLE;
				vtx_d          = 1'b0;
				start_d        = off_q;
			end else if (cont) begin
				off_d = q;
				if ((mode_q == MODE_INT) && (char_in == ott_pkg::CH_DOT)) begin
					mode_d = MODE_FRAC;
				end
				if (mode_q == MODE_IDENT) begin
					vtx_d = 1'b0;
				end
			end else if (mode_q == MODE_COMMENT) begin
				off_d = q;
				if (char_in == ott_pkg::CH_NEWLINE) begin
					line_d         = line_inc;
					start_d        = q;
					mode_d         = MODE_IDLE;
					own_v          = 1'b1;
					own_tok.kind   = ott_pkg::KIND_NEWLINE;
					own_tok.offset = q_w[15:0];
					own_tok.line   = inc_w[15:0];
				end
			end else begin
				// open token ends here, byte starts afresh from idle
				flush  = pending;
				mode_d = MODE_IDLE;
				vtx_d  = 1'b0;
				off_d  = q;
				if (ott_pkg::is_blank(char_in)) begin
					start_d = q;
				end else if (char_in == ott_pkg::CH_SLASH) begin
					start_d        = q;
					own_v          = 1'b1;
					own_tok.kind   = ott_pkg::KIND_SLASH;
					own_tok.offset = p_w[15:0];
					own_tok.length = 16'd1;
					own_tok.line   = line_w[15:0];
				end else if (char_in == ott_pkg::CH_NEWLINE) begin
					start_d        = q;
					line_d         = line_inc;
					own_v          = 1'b1;
					own_tok.kind   = ott_pkg::KIND_NEWLINE;
					own_tok.offset = p_w[15:0];
					own_tok.length = 16'd1;
					own_tok.line   = inc_w[15:0];
				end else if ((char_in == ott_pkg::CH_PLUS) || (char_in == ott_pkg::CH_MINUS) ||
						ott_pkg::is_digit(char_in)) begin
					start_d = off_q;
					mode_d  = MODE_INT;
				end else if (char_in == ott_pkg::CH_HASH) begin
					mode_d = MODE_COMMENT;
				end else if (ott_pkg::is_alpha(char_in)) begin
					start_d = off_q;
					mode_d  = MODE_IDENT;
					vtx_d   = (char_in == ott_pkg::CH_VERTEX);
				end else begin
					own_v          = 1'b1;
					own_tok.kind   = ott_pkg::KIND_ERROR;
					own_tok.offset = q_w[15:0];
					own_tok.line   = line_w[15:0];
					mode_d         = MODE_HALT;
				end
			end
		end
	end

	// pack: flushed token first, then the byte's own token
	always_comb begin
		lex.count = 2'd0;
		lex.tok0  = '0;
		lex.tok1  = '0;
		if (flush && own_v) begin
			lex.count     = 2'd2;
			lex.tok0      = pend_tok;
			lex.tok1      = own_tok;
			lex.tok1.last = 1'b1;
		end else if (flush) begin
			lex.count     = 2'd1;
			lex.tok0      = pend_tok;
			lex.tok0.last = 1'b1;
		end else if (own_v) begin
			lex.count     = 2'd1;
			lex.tok0      = own_tok;
			lex.tok0.last = 1'b1;
		end
	end

	// scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			off_q   <= '0;
			start_q <= '0;
			line_q  <= LINE_BITS'(1);
			vtx_q   <= 1'b0;
		end else begin
			mode_q  <= mode_d;
			off_q   <= off_d;
			start_q <= start_d;
			line_q  <= line_d;
			vtx_q   <= vtx_d;
		end
	end

	`ASSERT_PROP(a_halt_silent, (mode_q == MODE_HALT) |-> (lex.count == 2'd0), "token after halt")
	`ASSERT_PROP(a_halt_sticks, (mode_q == MODE_HALT) |=> (mode_q == MODE_HALT), "left halt")
	`ASSERT_NEVER(a_vtx_only_ident, vtx_q && (mode_q != MODE_IDENT), "vertex flag outside identifier")

endmodule

### rtl/core/ott_token_fifo.sv
// ---------------------------------------------------------------------------
// ott_token_fifo
// four-entry result queue, takes up to two tokens a cycle, gives one
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ott_token_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  ott_pkg::lex_out_t lex,
	output logic              room,
	ott_token_if.source       tokens
);

	localparam int DEPTH = 4;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	ott_pkg::token_t  mem [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q, wr_next;
	logic [CNT_W-1:0] count_q;
	logic             pop;
	ott_pkg::token_t  head;

	// space for two more tokens, so a byte's tokens always fit once it leaves the input register
	assign room    = (count_q <= CNT_W'(DEPTH - 2));
	assign wr_next = wr_q + PTR_W'(1);
	assign head    = mem[rd_q];
	assign pop     = tokens.valid && tokens.ready;

	// output side
	assign tokens.valid        = (count_q != '0);
	assign tokens.token_kind   = head.kind;
	assign tokens.token_offset = head.offset;
	assign tokens.token_length = head.length;
	assign tokens.line_number  = head.line;
	assign tokens.last_of_run  = head.last;

	// token storage
	always_ff @(posedge clk) begin
		if (lex.count != 2'd0) begin
			mem[wr_q] <= lex.tok0;
		end
		if (lex.count == 2'd2) begin
			mem[wr_next] <= lex.tok1;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + PTR_W'(lex.count);
			rd_q    <= rd_q + PTR_W'(pop);
			count_q <= count_q + CNT_W'(lex.count) - CNT_W'(pop);
		end
	end

	`ASSERT_NEVER(a_count_range, count_q > CNT_W'(DEPTH), "fill count beyond depth")
	`ASSERT_NEVER(a_no_overflow, (CNT_W'(lex.count) + count_q) > CNT_W'(DEPTH),
		"push into full queue")

endmodule

### rtl/core/obj_text_tokenizer_core.sv
// ---------------------------------------------------------------------------
// obj_text_tokenizer_core
// streaming lexer for obj text: bytes in, typed tokens out
// ---------------------------------------------------------------------------
//  channel  | dir | payload                                          | per transfer
//  text     | in  | char_in[8], at_end                               | one byte or end
//  tokens   | out | token_kind[3], token_offset[16], token_length[16], | one token
//           |     | line_number[16], last_of_run                     |
//
// one byte per cycle sustained while the queue has room; a byte goes through an
// input register, the scan logic and a four-entry token queue, which registers
// its tokens before they show. a byte yields at most two tokens; the queue output
// port gives one per cycle, so a long run of two-token bytes is paced by it.
// reset clears the scan state to idle, offset zero and line one.
// text.ready drops only when the input register is full and the queue has
// fewer than two free entries; after an error token no more tokens appear.
module obj_text_tokenizer_core #(
	parameter int POS_BITS  = 16,
	parameter int LINE_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	ott_byte_if.sink    text,
	ott_token_if.source tokens
);

	logic              valid_s1;
	logic [7:0]        char_s1;
	logic              end_s1;
	logic              room;
	logic              fire;
	ott_pkg::lex_out_t lex;

	// byte leaves the input register when the queue has room for its tokens
	assign fire       = valid_s1 && room;
	assign text.ready = !valid_s1 || fire;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.ready) begin
			valid_s1 <= text.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text.valid && text.ready) begin
			char_s1 <= text.char_in;
			end_s1  <= text.at_end;
		end
	end

	ott_lexer #(
		.POS_BITS (POS_BITS),
		.LINE_BITS(LINE_BITS)
	) u_lexer (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.char_in(char_s1),
		.at_end (end_s1),
		.lex    (lex)
	);

	ott_token_fifo u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.lex   (lex),
		.room  (room),
		.tokens(tokens)
	);

endmodule

### sim/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// self-checking bench for obj_text_tokenizer_core: drives obj text one byte
// per transfer, predicts every token in a local scanner model and compares
// each token field by field, with random gaps on both channels, one long
// output stall and an error halt at the end of the run
// ---------------------------------------------------------------------------
module testbench;

	localparam int HOLD_CYCLES    = 200;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 20;
	localparam int RANDOM_ITEMS   = 1300;

	// scan modes of the local scanner model
	typedef enum logic [2:0] {
		SCAN_IDLE,
		SCAN_INT,
		SCAN_FRAC,
		SCAN_IDENT,
		SCAN_COMMENT,
		SCAN_HALT
	} scan_mode_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	ott_byte_if  text_bus();
	ott_token_if token_bus();

	obj_text_tokenizer_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text_bus),
		.tokens (token_bus)
	);

	always #2 clk = ~clk;

	// scanner model state
	scan_mode_t  lex_mode;
	logic [15:0] next_pos;
	logic [15:0] word_start;
	logic [15:0] cur_line;
	logic        only_v;

	ott_pkg::token_t step_tokens[$];
	ott_pkg::token_t tokens_due[$];
	logic [7:0]      text_q[$];

	int bytes_sent    = 0;
	int tokens_seen   = 0;
	int fail_count    = 0;
	int hold_request  = 0;
	bit no_gaps       = 1'b0;

	// byte classes
	function automatic logic digit_char(input logic [7:0] c);
		return (c >= "0") && (c <= "9");
	endfunction

	function automatic logic letter_char(input logic [7:0] c);
		return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
	endfunction

	function automatic logic blank_char(input logic [7:0] c);
		return (c == 8'h20) || (c == 8'h09) || (c == 8'h0B) || (c == 8'h0C) || (c == 8'h0D);
	endfunction

	// token of the current step, on the current line
	function automatic void add_token(input logic [2:0] kind, input logic [15:0] off,
		input logic [15:0] len);
		ott_pkg::token_t t;
		t.kind   = kind;
		t.offset = off;
		t.length = len;
		t.line   = cur_line;
		t.last   = 1'b0;
		step_tokens.push_back(t);
	endfunction

	// emit the number or identifier still open
	function automatic void close_word();
		if (lex_mode == SCAN_IDENT) begin
			add_token(only_v ? ott_pkg::KIND_VERTEX : ott_pkg::KIND_IDENT, word_start,
				next_pos - word_start);
		end else if (lex_mode == SCAN_INT || lex_mode == SCAN_FRAC) begin
			add_token(ott_pkg::KIND_NUMBER, word_start, next_pos - word_start);
		end
		if (lex_mode != SCAN_COMMENT && lex_mode != SCAN_HALT) begin
			lex_mode = SCAN_IDLE;
			only_v   = 1'b0;
		end
	endfunction

	// advance the model by one accepted byte and queue the tokens it yields
	function automatic void predict_tokens(input logic [7:0] c, input logic fin);
		logic [15:0] p;
		logic [15:0] q;
		bit          consumed;
		p        = next_pos;
		q        = p + 16'd1;
		consumed = 1'b0;
		step_tokens.delete();
		if (lex_mode == SCAN_HALT) return;
		if (fin) begin
			// end marker: flush, then a zero-length newline, offset unchanged
			if (lex_mode == SCAN_COMMENT) lex_mode = SCAN_IDLE;
			close_word();
			add_token(ott_pkg::KIND_NEWLINE, p, 16'd0);
			lex_mode   = SCAN_IDLE;
			only_v     = 1'b0;
			word_start = p;
		end else begin
			case (lex_mode)
				SCAN_INT: begin
					if (digit_char(c)) begin
						consumed = 1'b1;
					end else if (c == ott_pkg::CH_DOT) begin
						lex_mode = SCAN_FRAC;
						consumed = 1'b1;
					end
				end
				SCAN_FRAC: begin
					consumed = digit_char(c);
				end
				SCAN_IDENT: begin
					if (letter_char(c) || digit_char(c)) begin
						only_v   = 1'b0;
						consumed = 1'b1;
					end
				end
				SCAN_COMMENT: begin
					consumed = 1'b1;
					// comment newline counts a line, zero length past the newline
					if (c == ott_pkg::CH_NEWLINE) begin
						cur_line   = cur_line + 16'd1;
						word_start = q;
						lex_mode   = SCAN_IDLE;
						add_token(ott_pkg::KIND_NEWLINE, q, 16'd0);
					end
				end
				default: ;
			endcase
			if (!consumed) begin
				close_word();
				// byte starts a new token
				if (blank_char(c)) begin
					word_start = q;
				end else if (c == ott_pkg::CH_SLASH) begin
					add_token(ott_pkg::KIND_SLASH, p, 16'd1);
					word_start = q;
				end else if (c == ott_pkg::CH_NEWLINE) begin
					cur_line = cur_line + 16'd1;
					add_token(ott_pkg::KIND_NEWLINE, p, 16'd1);
					word_start = q;
				end else if (c == ott_pkg::CH_PLUS || c == ott_pkg::CH_MINUS ||
						digit_char(c)) begin
					word_start = p;
					lex_mode   = SCAN_INT;
				end else if (c == ott_pkg::CH_HASH) begin
					lex_mode = SCAN_COMMENT;
				end else if (letter_char(c)) begin
					word_start = p;
					lex_mode   = SCAN_IDENT;
					only_v     = (c == ott_pkg::CH_VERTEX);
				end else begin
					add_token(ott_pkg::KIND_ERROR, q, 16'd0);
					lex_mode = SCAN_HALT;
				end
			end
			next_pos = q;
		end
		if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
		foreach (step_tokens[i]) tokens_due.push_back(step_tokens[i]);
	endfunction

	// one byte transfer on the text channel, called at a falling edge
	task automatic send_byte(input logic [7:0] c, input logic fin);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			text_bus.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		text_bus.valid   = 1'b1;
		text_bus.char_in = c;
		text_bus.at_end  = fin;
		do @(posedge clk); while (!text_bus.ready);
		predict_tokens(c, fin);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
	endtask

	task automatic send_queue();
		foreach (text_q[i]) send_byte(text_q[i], 1'b0);
		text_q.delete();
	endtask

	// random text pieces
	function automatic logic [7:0] blank_byte();
		case ($urandom_range(0, 7))
			0: return 8'h09;
			1: return 8'h0B;
			2: return 8'h0C;
			3: return 8'h0D;
			default: return 8'h20;
		endcase
	endfunction

	function automatic logic [7:0] letter_byte();
		if ($urandom_range(0, 1)) return 8'("a" + $urandom_range(0, 25));
		return 8'("A" + $urandom_range(0, 25));
	endfunction

	function automatic void put_blank();
		text_q.push_back(blank_byte());
		if ($urandom_range(0, 3) == 0) text_q.push_back(blank_byte());
	endfunction

	function automatic void put_digits(input int n);
		repeat (n) text_q.push_back(8'("0" + $urandom_range(0, 9)));
	endfunction

	// optional sign, digits, optional dot and fraction; never a lone dot
	function automatic void put_number();
		int sign_pick;
		sign_pick = $urandom_range(0, 2);
		if (sign_pick == 1) text_q.push_back(ott_pkg::CH_PLUS);
		if (sign_pick == 2) text_q.push_back(ott_pkg::CH_MINUS);
		put_digits($urandom_range(sign_pick == 0 ? 1 : 0, 4));
		if ($urandom_range(0, 1)) begin
			text_q.push_back(ott_pkg::CH_DOT);
			put_digits($urandom_range(0, 3));
		end
	endfunction

	// face index forms: i, i/t, i//n, i/t/n
	function automatic void put_index();
		int form;
		form = $urandom_range(0, 3);
		if ($urandom_range(0, 5) == 0) text_q.push_back(ott_pkg::CH_MINUS);
		put_digits($urandom_range(1, 3));
		if (form != 0) begin
			text_q.push_back(ott_pkg::CH_SLASH);
			if (form != 2) put_digits($urandom_range(1, 3));
		end
		if (form >= 2) begin
			text_q.push_back(ott_pkg::CH_SLASH);
			put_digits($urandom_range(1, 3));
		end
	endfunction

	function automatic void put_word();
		text_q.push_back(($urandom_range(0, 3) == 0) ? ott_pkg::CH_VERTEX : letter_byte());
		repeat ($urandom_range(0, 5)) begin
			if ($urandom_range(0, 2) == 0) put_digits(1);
			else text_q.push_back(letter_byte());
		end
	endfunction

	// noise byte that cannot raise an error in the present scan mode
	function automatic logic [7:0] safe_byte();
		if (lex_mode == SCAN_COMMENT) begin
			if ($urandom_range(0, 5) == 0) return ott_pkg::CH_NEWLINE;
			return 8'($urandom_range(0, 255));
		end
		case ($urandom_range(0, 9))
			0, 1: return letter_byte();
			2, 3: return 8'("0" + $urandom_range(0, 9));
			4: return $urandom_range(0, 1) ? ott_pkg::CH_PLUS : ott_pkg::CH_MINUS;
			5: return ott_pkg::CH_SLASH;
			6: return blank_byte();
			7: return ott_pkg::CH_NEWLINE;
			8: return ott_pkg::CH_HASH;
			default: return (lex_mode == SCAN_INT) ? ott_pkg::CH_DOT :
				8'("0" + $urandom_range(0, 9));
		endcase
	endfunction

	task automatic send_noise(input int n);
		repeat (n) send_byte(safe_byte(), 1'b0);
	endtask

	// token kinds, sign forms, comments and end markers in short hand-made text
	task automatic test_directed();
		send_text("v -1.5/+.\n");
		send_text("vt9#x\n");
		send_text("-/");
		send_text("\tZ");
		send_byte(8'hFF, 1'b1);
		send_byte(8'h00, 1'b1);
		send_text("#");
		send_byte(8'h5A, 1'b1);
	endtask

	// receiver stalls long while two-token bytes keep coming
	task automatic test_output_stall();
		no_gaps      = 1'b1;
		hold_request = HOLD_CYCLES;
		for (int k = 0; k < 48; k++)
			send_byte((k % 2 == 0) ? 8'("7") : ott_pkg::CH_SLASH, 1'b0);
		send_byte(ott_pkg::CH_NEWLINE, 1'b0);
		no_gaps = 1'b0;
	endtask

	// random obj-like lines, mixed with noise and end markers
	task automatic test_random_text();
		int stop_at;
		int line_kind;
		logic [7:0] b;
		stop_at = bytes_sent + RANDOM_ITEMS;
		while (bytes_sent < stop_at) begin
			if ($urandom_range(0, 15) == 0) no_gaps = !no_gaps;
			line_kind = $urandom_range(0, 9);
			text_q.delete();
			case (line_kind)
				0, 1, 2: begin
					text_q.push_back(ott_pkg::CH_VERTEX);
					repeat (3) begin
						put_blank();
						put_number();
					end
					if ($urandom_range(0, 1)) put_blank();
					text_q.push_back(ott_pkg::CH_NEWLINE);
				end
				3, 4: begin
					text_q.push_back("f");
					repeat ($urandom_range(1, 4)) begin
						put_blank();
						put_index();
					end
					text_q.push_back(ott_pkg::CH_NEWLINE);
				end
				5: begin
					// comment body takes any byte but newline
					text_q.push_back(ott_pkg::CH_HASH);
					repeat ($urandom_range(0, 12)) begin
						b = 8'($urandom_range(0, 255));
						text_q.push_back((b == ott_pkg::CH_NEWLINE) ? 8'hFF : b);
					end
					if ($urandom_range(0, 3) == 0) begin
						send_queue();
						send_byte(8'($urandom_range(0, 255)), 1'b1);
					end else begin
						text_q.push_back(ott_pkg::CH_NEWLINE);
					end
				end
				6: begin
					put_word();
					repeat ($urandom_range(0, 3)) begin
						put_blank();
						if ($urandom_range(0, 1)) put_word();
						else put_number();
					end
					text_q.push_back(ott_pkg::CH_NEWLINE);
				end
				7, 8: send_noise($urandom_range(1, 10));
				default: send_byte(8'($urandom_range(0, 255)), 1'b1);
			endcase
			send_queue();
		end
		no_gaps = 1'b0;
	endtask

	// a bad byte closes the open number, gives an error and halts the block
	task automatic test_error_halt();
		logic [7:0] bad;
		case ($urandom_range(0, 3))
			0: bad = 8'h00;
			1: bad = 8'h7F;
			2: bad = 8'h21;
			default: bad = 8'($urandom_range(128, 255));
		endcase
		send_text("4");
		send_byte(bad, 1'b0);
		send_noise(6);
		send_byte(8'h00, 1'b1);
		send_text("v 1\n");
	endtask

	function automatic void check_field(input string field, input logic [15:0] want,
		input logic [15:0] got);
		if (want !== got) begin
			$display("%0t: token %s mismatch, expected %0d, actual %0d", $time, field, want, got);
			fail_count++;
		end
	endfunction

	// token receiver: random ready gaps, one long hold on request
	initial begin : token_sink
		int wait_cycles;
		ott_pkg::token_t want;
		token_bus.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			wait_cycles = no_gaps ? 0 : $urandom_range(0, 7);
			if (hold_request > 0) begin
				wait_cycles  = hold_request;
				hold_request = 0;
			end
			if (wait_cycles > 0) begin
				token_bus.ready = 1'b0;
				repeat (wait_cycles) @(negedge clk);
			end
			token_bus.ready = 1'b1;
			do @(posedge clk); while (!token_bus.valid);
			tokens_seen++;
			if (tokens_due.size() == 0) begin
				$display("%0t: unexpected token, expected none, actual kind %0d offset %0d",
					$time, token_bus.token_kind, token_bus.token_offset);
				fail_count++;
			end else begin
				want = tokens_due.pop_front();
				check_field("kind", 16'(want.kind), 16'(token_bus.token_kind));
				check_field("offset", want.offset, token_bus.token_offset);
				check_field("length", want.length, token_bus.token_length);
				check_field("line", want.line, token_bus.line_number);
				check_field("last", 16'(want.last), 16'(token_bus.last_of_run));
			end
			@(negedge clk);
		end
	end

	// watchdog on cycles with no transfer on either channel
	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((text_bus.valid && text_bus.ready) || (token_bus.valid && token_bus.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no transfer for %0d cycles, %0d tokens outstanding",
					$time, idle_cycles, tokens_due.size());
				$display("obj_text_tokenizer_core verification failed");
				$finish;
			end
		end
	end

	// test sequence
	initial begin
		text_bus.valid   = 1'b0;
		text_bus.char_in = 8'h00;
		text_bus.at_end  = 1'b0;
		lex_mode   = SCAN_IDLE;
		next_pos   = 16'd0;
		word_start = 16'd0;
		cur_line   = 16'd1;
		only_v     = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_output_stall();
		test_random_text();
		test_error_halt();
		text_bus.valid = 1'b0;

		while (tokens_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("run covered %0d byte and end-marker transfers and %0d checked tokens,",
			bytes_sent, tokens_seen);
		$display("with a %0d-cycle output hold and a final error halt; %0d mismatches",
			HOLD_CYCLES, fail_count);
		if (fail_count == 0) begin
			$display("obj_text_tokenizer_core verification clean");
		end else begin
			$display("obj_text_tokenizer_core verification failed");
		end
		$finish;
	end

endmodule
